// File: rtl/lottery_arbiter_macros.svh
// Assertion macros used by the lottery arbiter checker.
`ifndef LOTTERY_ARBITER_MACROS_SVH
`define LOTTERY_ARBITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lottery_arbiter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lottery_arbiter: next-cycle check failed");

`endif

// File: rtl/lta_pkg.sv
// Package: constants, types and codes of the lottery arbiter.
`default_nettype none
package lta_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FIELD_IDX_W = 6;
    localparam int ADDR_W     = (IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W;
    localparam int TICKET_W   = 16;
    localparam int SUM_W      = $clog2(ENTRIES * 65535 + 1);
    localparam int TOTAL_W    = 22;
    localparam int TOTAL_MAX  = 2 ** TOTAL_W - 1;
    localparam int CMP_W      = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int RAND_W     = 32;
    localparam int DIV_STEPS  = RAND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_DRAW  = 1'b1;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic                run;
    } t_slot;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [SUM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_POST
    } t_state;

endpackage
`default_nettype wire

// File: rtl/lta_cell.sv
// One ring cell: holds an entry's tickets and runnable flag.
`default_nettype none
module lta_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_wr,
    input  wire [lta_pkg::TICKET_W-1:0]  i_wr_ticket,
    input  wire                          i_wr_run,
    input  wire                          i_shift,
    input  lta_pkg::t_slot               i_nbr,
    output lta_pkg::t_slot               o_slot
);
    import lta_pkg::*;

    t_slot r_slot;

    // Writes only happen while idle; shifts only during a draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_wr) begin
            r_slot <= '{ticket: i_wr_ticket, run: i_wr_run};
        end else if (i_shift) begin
            r_slot <= i_nbr;
        end
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

// File: rtl/lta_mod.sv
// Restoring modulo unit: one remainder bit per cycle.
`default_nettype none
module lta_mod (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lta_pkg::t_div_req i_req,
    output lta_pkg::t_div_rsp o_rsp
);
    import lta_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_rem;
    logic [RAND_W-1:0]    r_dvd;
    logic [SUM_W-1:0]     r_div;

    logic [SUM_W:0]       w_trial;
    logic                 w_ge;
    logic [SUM_W-1:0]     w_rem_next;

    // rem < div, so the trial stays below twice the divisor
    always_comb begin
        w_trial    = {r_rem, r_dvd[RAND_W-1]};
        w_ge       = (w_trial >= {1'b0, r_div});
        w_rem_next = w_ge ? SUM_W'(w_trial - {1'b0, r_div}) : SUM_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_dvd <= {r_dvd[RAND_W-2:0], 1'b0};
        end
    end

    assign o_rsp = '{done: r_done, rem: r_rem};

endmodule
`default_nettype wire

// File: rtl/lta_ctrl.sv
// Sequencer: ring passes, modulo hand-off, winner pick and result register.
`default_nettype none
module lta_ctrl (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_func,
    input  wire [lta_pkg::RAND_W-1:0]         i_random,
    input  lta_pkg::t_slot                    i_head,
    output logic                              o_shift,
    output lta_pkg::t_slot                    o_fb,
    output lta_pkg::t_div_req                 o_div_req,
    input  lta_pkg::t_div_rsp                 i_div_rsp,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_out_win,
    output logic [lta_pkg::FIELD_IDX_W-1:0]   o_out_idx,
    output logic [lta_pkg::TOTAL_W-1:0]       o_out_total
);
    import lta_pkg::*;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_cnt, n_cnt;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [RAND_W-1:0]      r_rand, n_rand;
    logic [SUM_W-1:0]       r_pick, n_pick;
    logic [SUM_W-1:0]       r_run_sum, n_run_sum;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_win_idx, n_win_idx;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_win, n_out_win;
    logic [FIELD_IDX_W-1:0] r_out_idx, n_out_idx;
    logic [TOTAL_W-1:0]     r_out_total, n_out_total;

    logic                   w_last;
    logic [SUM_W-1:0]       w_acc;
    logic                   w_hit;
    logic [CMP_W-1:0]       w_sum_ext;
    logic [TOTAL_W-1:0]     w_total;

    always_comb begin
        w_last    = (r_cnt == IDX_W'(ENTRIES - 1));
        w_acc     = r_run_sum + SUM_W'(i_head.ticket);
        w_hit     = !r_found && i_head.run && (w_acc > r_pick);
        w_sum_ext = CMP_W'(r_sum);
        w_total   = (w_sum_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                    : TOTAL_W'(w_sum_ext);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_rand      = r_rand;
        n_pick      = r_pick;
        n_run_sum   = r_run_sum;
        n_found     = r_found;
        n_win_idx   = r_win_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_win   = r_out_win;
        n_out_idx   = r_out_idx;
        n_out_total = r_out_total;
        o_in_ready  = 1'b0;
        o_shift     = 1'b0;
        o_fb        = i_head;
        o_div_req   = '{start: 1'b0, dividend: r_rand, divisor: r_sum};

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_sum   = '0;
                    n_found = 1'b0;
                    if (i_func == FUNC_DRAW) begin
                        n_rand  = i_random;
                        n_cnt   = '0;
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_SUM: begin
                // first trip around the ring: total of runnable tickets
                o_shift = 1'b1;
                if (i_head.run) begin
                    n_sum = r_sum + SUM_W'(i_head.ticket);
                end
                n_cnt = r_cnt + IDX_W'(1);
                if (w_last) begin
                    n_cnt = '0;
                    if (n_sum == '0) begin
                        n_state = ST_POST;
                    end else begin
                        o_div_req = '{start: 1'b1, dividend: r_rand, divisor: n_sum};
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_rsp.done) begin
                    n_pick    = i_div_rsp.rem;
                    n_run_sum = '0;
                    n_cnt     = '0;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                // second trip: first runnable running sum above pick wins
                o_shift = 1'b1;
                if (i_head.run) begin
                    n_run_sum = w_acc;
                end
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_win_idx = r_cnt;
                    o_fb.run  = 1'b0;
                end
                n_cnt = r_cnt + IDX_W'(1);
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_win   = r_found;
                    n_out_idx   = r_found ? FIELD_IDX_W'(r_win_idx) : '0;
                    n_out_total = w_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_rand      <= n_rand;
        r_pick      <= n_pick;
        r_run_sum   <= n_run_sum;
        r_found     <= n_found;
        r_win_idx   <= n_win_idx;
        r_out_win   <= n_out_win;
        r_out_idx   <= n_out_idx;
        r_out_total <= n_out_total;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_win   = r_out_win;
    assign o_out_idx   = r_out_idx;
    assign o_out_total = r_out_total;

endmodule
`default_nettype wire

// File: rtl/lottery_arbiter.sv
// Top level: lottery arbiter built from a ring of entry cells.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-------------
//  s_axis   | in  | entry_index, ticket_count, runnable, rand  | func
//  m_axis   | out | winner_index, ticket_total                 | winner_valid
//
// Write item: lands in its cell at the accept edge; the result is then posted
// from ST_POST once the result register is free.
// Draw item: a trip of the entries around the cell ring, the one-bit-per-cycle
// modulo and a second trip; a zero runnable total skips the last two.
// Reset (synchronous, active low) clears every cell, so no clearing pass.
// The next item is taken while a result waits; it posts once that register frees.
`default_nettype none
module lottery_arbiter (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] entry_index, [21:6] ticket_count, [22] runnable,
    // [54:23] random_value, [55] zero
    input  wire [lta_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] func
    input  wire                               s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [5:0] winner_index, [27:6] ticket_total, [31:28] zero
    output logic [lta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] winner_valid
    output logic                              m_axis_tuser
);
    import lta_pkg::*;

    localparam int IN_IDX_LSB  = 0;
    localparam int IN_TKT_LSB  = IN_IDX_LSB + FIELD_IDX_W;
    localparam int IN_RUN_BIT  = IN_TKT_LSB + TICKET_W;
    localparam int IN_RAND_LSB = IN_RUN_BIT + 1;
    localparam int OUT_USED_W  = FIELD_IDX_W + TOTAL_W;

    logic [FIELD_IDX_W-1:0] w_in_idx;
    logic [TICKET_W-1:0]    w_in_ticket;
    logic                   w_in_run;
    logic [RAND_W-1:0]      w_in_rand;
    logic                   w_wr;

    t_slot                  w_slot [ENTRIES];
    t_slot                  w_fb;
    logic                   w_shift;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;

    logic                   w_out_win;
    logic [FIELD_IDX_W-1:0] w_out_idx;
    logic [TOTAL_W-1:0]     w_out_total;

    assign w_in_idx    = s_axis_tdata[IN_IDX_LSB +: FIELD_IDX_W];
    assign w_in_ticket = s_axis_tdata[IN_TKT_LSB +: TICKET_W];
    assign w_in_run    = s_axis_tdata[IN_RUN_BIT];
    assign w_in_rand   = s_axis_tdata[IN_RAND_LSB +: RAND_W];

    // write lands on its own cell; indexes past the ring match no cell
    assign w_wr = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WRITE);

    // Ring: each cell takes its upper neighbor, the top cell takes the head
    // back (with the winner's flag dropped during the walk).
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_slot w_nbr;
        if (g == ENTRIES - 1) begin : g_top
            assign w_nbr = w_fb;
        end else begin : g_mid
            assign w_nbr = w_slot[g + 1];
        end

        lta_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (w_wr && (ADDR_W'(w_in_idx) == ADDR_W'(g))),
            .i_wr_ticket (w_in_ticket),
            .i_wr_run    (w_in_run),
            .i_shift     (w_shift),
            .i_nbr       (w_nbr),
            .o_slot      (w_slot[g])
        );
    end

    lta_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_random    (w_in_rand),
        .i_head      (w_slot[0]),
        .o_shift     (w_shift),
        .o_fb        (w_fb),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_win   (w_out_win),
        .o_out_idx   (w_out_idx),
        .o_out_total (w_out_total)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, w_out_total, w_out_idx};
    assign m_axis_tuser = w_out_win;

endmodule
`default_nettype wire

// File: rtl/lta_chk.sv
// Port-level checker for the lottery arbiter, bound to the top level.
`default_nettype none
`include "lottery_arbiter_macros.svh"
module lta_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_tvalid,
    input wire                             i_s_tready,
    input wire                             i_m_tvalid,
    input wire                             i_m_tready,
    input wire [lta_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input wire                             i_m_tuser
);
    import lta_pkg::*;

    // stalled result holds
    `LTA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
    // one item in flight: input side closes right after an accept
    `LTA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)
    // no winner: index and total are zero
    `LTA_ASSERT_SAME(a_nowin_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, i_m_tdata == '0)
    // a winner implies a nonzero ticket total
    `LTA_ASSERT_SAME(a_win_total, i_clk, i_rst_n, i_m_tvalid && i_m_tuser, i_m_tdata[FIELD_IDX_W +: TOTAL_W] != '0)

endmodule

bind lottery_arbiter lta_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
`default_nettype wire
